// ===== design/dbd_pkg.sv =====
package dbd_pkg;

    localparam int SAMPLE_W = 12;
    localparam int TICK_W   = 16;

    // item op codes
    localparam logic [2:0] OP_TICK         = 3'd0;
    localparam logic [2:0] OP_EDGE         = 3'd1;
    localparam logic [2:0] OP_BASE_RESET   = 3'd2;
    localparam logic [2:0] OP_FORCE_CONN   = 3'd3;
    localparam logic [2:0] OP_FORCE_DISC   = 3'd4;
    localparam logic [2:0] OP_FORCE_REL    = 3'd5;

    // base status codes
    localparam logic [1:0] ST_UNKNOWN      = 2'd0;
    localparam logic [1:0] ST_DISCONNECTED = 2'd1;
    localparam logic [1:0] ST_CONNECTED    = 2'd2;

    // config register indexes
    localparam logic [2:0] REG_DEBOUNCE      = 3'd0;
    localparam logic [2:0] REG_UNPLUG_LOW    = 3'd1;
    localparam logic [2:0] REG_UNPLUG_HIGH   = 3'd2;
    localparam logic [2:0] REG_ATTACHED_LOW  = 3'd3;
    localparam logic [2:0] REG_ATTACHED_HIGH = 3'd4;
    localparam logic [2:0] REG_PLUG_LOW      = 3'd5;
    localparam logic [2:0] REG_PLUG_HIGH     = 3'd6;
    localparam logic [2:0] REG_DETACHED_LOW  = 3'd7;

    // reset values
    localparam logic [TICK_W-1:0]   RST_DEBOUNCE      = 16'd20;
    localparam logic [SAMPLE_W-1:0] RST_UNPLUG_LOW    = 12'd20;
    localparam logic [SAMPLE_W-1:0] RST_UNPLUG_HIGH   = 12'd40;
    localparam logic [SAMPLE_W-1:0] RST_ATTACHED_LOW  = 12'd2050;
    localparam logic [SAMPLE_W-1:0] RST_ATTACHED_HIGH = 12'd2300;
    localparam logic [SAMPLE_W-1:0] RST_PLUG_LOW      = 12'd450;
    localparam logic [SAMPLE_W-1:0] RST_PLUG_HIGH     = 12'd600;
    localparam logic [SAMPLE_W-1:0] RST_DETACHED_LOW  = 12'd2800;

    typedef struct packed {
        logic [2:0]          op;
        logic [SAMPLE_W-1:0] sample_mv;
        logic                sample_error;
        logic                power_request;
    } req_item_t;

    typedef struct packed {
        logic [1:0] base_state;
        logic       base_power_on;
        logic       comm_pulldown_level;
        logic       standalone_mode;
        logic       state_changed;
        logic       status_unclear;
    } rsp_item_t;

    typedef struct packed {
        logic [TICK_W-1:0]   debounce_ticks;
        logic [SAMPLE_W-1:0] unplug_low_mv;
        logic [SAMPLE_W-1:0] unplug_high_mv;
        logic [SAMPLE_W-1:0] attached_low_mv;
        logic [SAMPLE_W-1:0] attached_high_mv;
        logic [SAMPLE_W-1:0] plug_low_mv;
        logic [SAMPLE_W-1:0] plug_high_mv;
        logic [SAMPLE_W-1:0] detached_low_mv;
    } cfg_t;

    // verdict of one sample check
    typedef struct packed {
        logic       unclear;
        logic       set_status;
        logic [1:0] new_status;
    } check_res_t;

endpackage

// ===== design/dbd_cfg_regs.sv =====
module dbd_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [2:0]                  wr_index,
    input  logic [31:0]                 wr_data,
    output dbd_pkg::cfg_t               cfg
);
    import dbd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks   <= RST_DEBOUNCE;
            cfg_reg.unplug_low_mv    <= RST_UNPLUG_LOW;
            cfg_reg.unplug_high_mv   <= RST_UNPLUG_HIGH;
            cfg_reg.attached_low_mv  <= RST_ATTACHED_LOW;
            cfg_reg.attached_high_mv <= RST_ATTACHED_HIGH;
            cfg_reg.plug_low_mv      <= RST_PLUG_LOW;
            cfg_reg.plug_high_mv     <= RST_PLUG_HIGH;
            cfg_reg.detached_low_mv  <= RST_DETACHED_LOW;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_DEBOUNCE:      cfg_reg.debounce_ticks   <= wr_data[TICK_W-1:0];
                REG_UNPLUG_LOW:    cfg_reg.unplug_low_mv    <= wr_data[SAMPLE_W-1:0];
                REG_UNPLUG_HIGH:   cfg_reg.unplug_high_mv   <= wr_data[SAMPLE_W-1:0];
                REG_ATTACHED_LOW:  cfg_reg.attached_low_mv  <= wr_data[SAMPLE_W-1:0];
                REG_ATTACHED_HIGH: cfg_reg.attached_high_mv <= wr_data[SAMPLE_W-1:0];
                REG_PLUG_LOW:      cfg_reg.plug_low_mv      <= wr_data[SAMPLE_W-1:0];
                REG_PLUG_HIGH:     cfg_reg.plug_high_mv     <= wr_data[SAMPLE_W-1:0];
                REG_DETACHED_LOW:  cfg_reg.detached_low_mv  <= wr_data[SAMPLE_W-1:0];
                default:           cfg_reg.debounce_ticks   <= cfg_reg.debounce_ticks;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/dbd_classify.sv =====
module dbd_classify (
    input  logic [1:0]                  status,
    input  logic [dbd_pkg::SAMPLE_W-1:0] sample,
    input  logic                        sample_error,
    input  dbd_pkg::cfg_t               cfg,
    output dbd_pkg::check_res_t         res
);
    import dbd_pkg::*;

    logic in_unplug;
    logic in_attached;
    logic in_plug;
    logic above_detached;

    // windows include both bounds
    assign in_unplug      = (sample >= cfg.unplug_low_mv)   && (sample <= cfg.unplug_high_mv);
    assign in_attached    = (sample >= cfg.attached_low_mv) && (sample <= cfg.attached_high_mv);
    assign in_plug        = (sample >= cfg.plug_low_mv)     && (sample <= cfg.plug_high_mv);
    assign above_detached = (sample >= cfg.detached_low_mv);

    always_comb
    begin
        res.unclear    = 1'b0;
        res.set_status = 1'b0;
        res.new_status = status;
        priority if (sample_error)
        begin
            res.unclear = 1'b1;
        end
        else if (status == ST_CONNECTED)
        begin
            priority if (in_unplug)
            begin
                res.set_status = 1'b1;
                res.new_status = ST_DISCONNECTED;
            end
            else if (!in_attached)
            begin
                res.unclear = 1'b1;
            end
            else
            begin
                // steady attached level: no change
            end
        end
        else
        begin
            priority if (in_plug)
            begin
                res.set_status = 1'b1;
                res.new_status = ST_CONNECTED;
            end
            else if (above_detached)
            begin
                // only unknown moves to disconnected here
                res.set_status = 1'b1;
                res.new_status = ST_DISCONNECTED;
            end
            else
            begin
                res.unclear = 1'b1;
            end
        end
    end

endmodule

// ===== design/detachable_base_detector_top.sv =====
// Detachable base detector.
//
// Request channel (req_valid / req_stall / req_item): one item per tick,
// detect edge, base reset or force command. Response channel (rsp_valid /
// rsp_stall / rsp_item): exactly one result item per request item, in order,
// carrying the base status after that item, the power grant, the comm pin
// level, standalone mode and the changed / unclear pulses.
// Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): always ready;
// write only while the block is idle.
//
// Timing: an item is captured into the input register, judged by a few
// window compares and 16-bit counter updates, and its result is then
// written to the result register, which drives rsp; a stalled result
// register holds it back. One item per cycle sustained while results are
// not stalled; the single status/counter update path is what bounds it.
// Stall: while rsp_stall holds a waiting result, one more item is still taken
// into the input register; req_stall rises only when both registers are full.
// Reset: status unknown, edges enabled, debounce expired, a check pending in
// 20 ticks, config registers at their defaults, both registers empty.
module detachable_base_detector_top #(
    parameter int RETRY_TICKS = 500,
    parameter int SAMPLE_BITS = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  dbd_pkg::req_item_t req_item,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output dbd_pkg::rsp_item_t rsp_item,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import dbd_pkg::*;

    localparam logic [TICK_W-1:0] RETRY = TICK_W'(RETRY_TICKS);
    localparam int SB = (SAMPLE_BITS > SAMPLE_W) ? SAMPLE_W : SAMPLE_BITS;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SB) - 64'd1);

    cfg_t       cfg;
    check_res_t chk;

    // pipeline registers
    logic       a_valid_reg;
    req_item_t  a_item_reg;
    logic       b_valid_reg;
    rsp_item_t  b_item_reg;
    rsp_item_t  b_item_next;
    logic       advance;

    // detector state
    logic [1:0]        status_reg,   status_next;
    logic [TICK_W-1:0] debounce_reg, debounce_next;
    logic [TICK_W-1:0] check_reg,    check_next;
    logic              edges_en_reg, edges_en_next;

    logic [TICK_W-1:0]   dl_dec;
    logic [TICK_W-1:0]   cl_dec;
    logic [TICK_W-1:0]   sched_debounce;
    logic [SAMPLE_W-1:0] sample;
    logic                unclear;
    logic                conn;

    assign cfg_ready = 1'b1;

    dbd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign sample = a_item_reg.sample_mv & SAMPLE_MASK;

    dbd_classify u_cls (
        .status       (status_reg),
        .sample       (sample),
        .sample_error (a_item_reg.sample_error),
        .cfg          (cfg),
        .res          (chk)
    );

    assign advance   = !b_valid_reg || !rsp_stall;
    assign req_stall = a_valid_reg && !advance;

    // zero delay counts as one tick
    assign sched_debounce = (cfg.debounce_ticks == '0) ? TICK_W'(1) : cfg.debounce_ticks;
    assign dl_dec = (debounce_reg != '0) ? debounce_reg - TICK_W'(1) : debounce_reg;
    assign cl_dec = check_reg - TICK_W'(1);

    always_comb
    begin
        status_next   = status_reg;
        debounce_next = debounce_reg;
        check_next    = check_reg;
        edges_en_next = edges_en_reg;
        unclear       = 1'b0;
        unique case (a_item_reg.op)
            OP_TICK:
            begin
                debounce_next = dl_dec;
                if (check_reg != '0)
                begin
                    check_next = cl_dec;
                    if (cl_dec == '0)
                    begin
                        if (dl_dec != '0)
                        begin
                            check_next = dl_dec;
                        end
                        else
                        begin
                            if (chk.set_status)
                            begin
                                status_next = chk.new_status;
                            end
                            if (chk.unclear)
                            begin
                                unclear    = 1'b1;
                                check_next = RETRY;
                            end
                        end
                    end
                end
            end
            OP_EDGE:
            begin
                if (edges_en_reg)
                begin
                    if (debounce_reg == '0)
                    begin
                        check_next = sched_debounce;
                    end
                    debounce_next = cfg.debounce_ticks;
                end
            end
            OP_BASE_RESET:
            begin
                status_next = ST_UNKNOWN;
                check_next  = RETRY;
            end
            OP_FORCE_CONN:
            begin
                edges_en_next = 1'b0;
                status_next   = ST_CONNECTED;
            end
            OP_FORCE_DISC:
            begin
                edges_en_next = 1'b0;
                status_next   = ST_DISCONNECTED;
            end
            OP_FORCE_REL:
            begin
                check_next    = sched_debounce;
                edges_en_next = 1'b1;
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    assign conn = (status_next == ST_CONNECTED);

    always_comb
    begin
        b_item_next.base_state          = status_next;
        b_item_next.base_power_on       = a_item_reg.power_request && conn;
        b_item_next.comm_pulldown_level = !conn;
        b_item_next.standalone_mode     = !conn;
        b_item_next.state_changed       = (status_next != status_reg);
        b_item_next.status_unclear      = unclear;
    end

    // control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
            status_reg   <= ST_UNKNOWN;
            debounce_reg <= '0;
            check_reg    <= RST_DEBOUNCE;
            edges_en_reg <= 1'b1;
        end
        else
        begin
            if (!req_stall)
            begin
                a_valid_reg <= req_valid;
            end
            if (advance)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (advance && a_valid_reg)
            begin
                status_reg   <= status_next;
                debounce_reg <= debounce_next;
                check_reg    <= check_next;
                edges_en_reg <= edges_en_next;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (!req_stall && req_valid)
        begin
            a_item_reg <= req_item;
        end
        if (advance && a_valid_reg)
        begin
            b_item_reg <= b_item_next;
        end
    end

    assign rsp_valid = b_valid_reg;
    assign rsp_item  = b_item_reg;

endmodule

// ===== design/dbd_checker.sv =====
module dbd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               req_valid,
    input logic               req_stall,
    input dbd_pkg::req_item_t req_item,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input dbd_pkg::rsp_item_t rsp_item,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [2:0]         cfg_index,
    input logic [31:0]        cfg_data
);
    import dbd_pkg::*;

    // power only while connected
    a_power_conn: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (!rsp_item.base_power_on || rsp_item.base_state == ST_CONNECTED))
        else $error("power granted while not connected");

    // pin level and standalone mode track the status
    a_pins: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.standalone_mode == (rsp_item.base_state != ST_CONNECTED)
                       && rsp_item.comm_pulldown_level == rsp_item.standalone_mode))
        else $error("pin outputs disagree with status");

    // a status change and an unclear check never come from the same item
    a_pulses: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp_item.state_changed && rsp_item.status_unclear))
        else $error("changed and unclear both set");

    // no illegal status code
    a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_item.base_state == ST_UNKNOWN
                       || rsp_item.base_state == ST_DISCONNECTED
                       || rsp_item.base_state == ST_CONNECTED))
        else $error("bad base state code");

    // stalled result holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
        else $error("stalled result changed");

endmodule

bind detachable_base_detector_top dbd_checker u_dbd_checker (.*);
